>>> rtl/core/swm_pkg.sv
// Package for the sliding window maximum block.
// Holds the window register constants and the control struct for the cell row.
// No dependencies.
package swm_pkg;

	localparam int WINDOW_SIZE_BITS = 7;
	localparam logic [WINDOW_SIZE_BITS-1:0] WINDOW_SIZE_RESET = 7'd3;

	// Control broadcast from the top level to every cell in the row.
	typedef struct packed {
		logic step;   // an item is accepted this cycle
		logic shift;  // trim one stale entry off the front, no item
		logic drop;   // the front entry leaves the window with this item
		logic start;  // the item begins a new sequence
	} cell_ctrl_t;

endpackage

>>> rtl/core/swm_if.sv
// Valid/ready channel interfaces for the sliding window maximum block.
// No dependencies.
interface swm_in_if #(parameter int SAMPLE_BITS = 16);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic                          start_req;

	modport source (output valid, output sample, output start_req, input ready);
	modport sink (input valid, input sample, input start_req, output ready);
endinterface

interface swm_out_if #(parameter int SAMPLE_BITS = 16);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] window_max;

	modport source (output valid, output window_max, input ready);
	modport sink (input valid, input window_max, output ready);
endinterface

>>> rtl/core/swm_cell.sv
// One cell of the candidate queue: a value, its age and a valid bit.
// Depends on swm_pkg for the control struct.
module swm_cell import swm_pkg::*; #(
	parameter int SAMPLE_BITS = 16,
	parameter int AGE_BITS    = 7
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cell_ctrl_t                    ctrl,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          prv_keep,
	input  logic                          nxt_valid,
	input  logic signed [SAMPLE_BITS-1:0] nxt_value,
	input  logic [AGE_BITS-1:0]           nxt_age,
	output logic                          keep,
	output logic                          valid,
	output logic signed [SAMPLE_BITS-1:0] value,
	output logic [AGE_BITS-1:0]           age,
	output logic signed [SAMPLE_BITS-1:0] next_value
);

	logic                          valid_q;
	logic signed [SAMPLE_BITS-1:0] value_q;
	logic [AGE_BITS-1:0]           age_q;
	logic                          src_valid;
	logic signed [SAMPLE_BITS-1:0] src_value;
	logic [AGE_BITS-1:0]           src_age;
	logic                          append;

	// When the front leaves, every entry moves one cell toward the front.
	always_comb begin
		src_valid = ctrl.drop ? nxt_valid : valid_q;
		src_value = ctrl.drop ? nxt_value : value_q;
		src_age   = ctrl.drop ? nxt_age : age_q;
		if (ctrl.start) begin
			src_valid = 1'b0;
		end
		keep       = src_valid && (src_value >= sample);
		append     = !keep && prv_keep;
		next_value = keep ? src_value : sample;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.step) begin
			valid_q <= keep || append;
		end else if (ctrl.shift) begin
			valid_q <= nxt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.step) begin
			value_q <= next_value;
			age_q   <= keep ? src_age + AGE_BITS'(1) : '0;
		end else if (ctrl.shift) begin
			value_q <= nxt_value;
			age_q   <= nxt_age;
		end
	end

	assign valid = valid_q;
	assign value = value_q;
	assign age   = age_q;

endmodule

>>> rtl/core/sliding_window_maximum.sv
// Sliding window maximum: top level with the cell row and the result register.
// Depends on swm_pkg, swm_if (channel interfaces) and swm_cell.
//
// Usage: samples come in on the samples channel (valid/ready), each with a
// start_req flag that clears the queue and begins a new sequence. Once
// window_size samples of a sequence have been taken, every sample gives one
// item on the maxima channel: the largest of the last window_size samples.
// Earlier samples of a sequence give no item. window_size is written through
// cfg_we/cfg_wdata while the block is idle; 0 acts as 1, values above
// MAX_WINDOW act as MAX_WINDOW.
// The result is registered: it is loaded into the output register at the
// edge that takes the sample and is offered from the next cycle on. One sample
// is taken per cycle while no trim is pending and the result register is free;
// every cell of the row compares its candidate with the new sample in parallel,
// and entries move at most one cell toward the front per cycle.
// After window_size is lowered, entries older than the new window are trimmed
// off the front one per cycle before ready rises again.
// Reset empties the queue, clears the sequence count and sets window_size to 3.
// When the receiver stalls, the result waits in the output register and ready
// stays low until it is taken, unless it is taken in the same cycle.
module sliding_window_maximum import swm_pkg::*; #(
	parameter int MAX_WINDOW  = 64,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	swm_in_if.sink                      samples,
	swm_out_if.source                   maxima,
	input  logic                        cfg_we,
	input  logic [WINDOW_SIZE_BITS-1:0] cfg_wdata
);

	// Window counts and ages never exceed MAX_WINDOW.
	localparam int WW = $clog2(MAX_WINDOW + 1);

	logic [WINDOW_SIZE_BITS-1:0]   window_size_q;
	logic [WW-1:0]                 seen_q;
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] out_max_q;

	logic [WW-1:0]  w_eff;
	logic [31:0]    ws_ext;
	logic           accept;
	logic           need_trim;
	logic           front_drop;
	logic [WW:0]    seen_inc;
	logic [WW-1:0]  seen_next;
	logic           has_result;
	cell_ctrl_t     ctrl;

	logic                          keep_w  [MAX_WINDOW];
	logic                          valid_w [MAX_WINDOW];
	logic signed [SAMPLE_BITS-1:0] value_w [MAX_WINDOW];
	logic [WW-1:0]                 age_w   [MAX_WINDOW];
	logic signed [SAMPLE_BITS-1:0] next_w  [MAX_WINDOW];

	// Effective window: the register clamped into one to MAX_WINDOW.
	always_comb begin
		ws_ext = 32'(window_size_q);
		if (ws_ext == 32'd0) begin
			ws_ext = 32'd1;
		end else if (ws_ext > 32'(MAX_WINDOW)) begin
			ws_ext = 32'(MAX_WINDOW);
		end
		w_eff = WW'(ws_ext);
	end

	// Between items every stored age is below the window, so at most the front
	// entry leaves with a new sample. A front entry at or past the window can
	// only be there after the window was lowered; it is trimmed first.
	assign need_trim  = valid_w[0] && (age_w[0] >= w_eff);
	assign front_drop = valid_w[0] &&
		(({1'b0, age_w[0]} + (WW+1)'(1)) >= {1'b0, w_eff});

	assign samples.ready = !need_trim && (!out_valid_q || maxima.ready);
	assign accept        = samples.valid && samples.ready;

	always_comb begin
		ctrl.step  = accept;
		ctrl.shift = need_trim;
		ctrl.drop  = front_drop;
		ctrl.start = samples.start_req;
	end

	// The row of cells: cell 0 holds the front of the queue, the oldest and
	// largest candidate. Each cell sees its front neighbor's keep decision to
	// find the append position and its back neighbor's entry for shifting.
	for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
		logic                          prv_keep;
		logic                          nxt_valid;
		logic signed [SAMPLE_BITS-1:0] nxt_value;
		logic [WW-1:0]                 nxt_age;

		if (i == 0) begin : g_front
			assign prv_keep = 1'b1;
		end else begin : g_inner
			assign prv_keep = keep_w[i-1];
		end

		if (i == MAX_WINDOW - 1) begin : g_back
			assign nxt_valid = 1'b0;
			assign nxt_value = '0;
			assign nxt_age   = '0;
		end else begin : g_link
			assign nxt_valid = valid_w[i+1];
			assign nxt_value = value_w[i+1];
			assign nxt_age   = age_w[i+1];
		end

		swm_cell #(
			.SAMPLE_BITS(SAMPLE_BITS),
			.AGE_BITS(WW)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.ctrl(ctrl),
			.sample(samples.sample),
			.prv_keep(prv_keep),
			.nxt_valid(nxt_valid),
			.nxt_value(nxt_value),
			.nxt_age(nxt_age),
			.keep(keep_w[i]),
			.valid(valid_w[i]),
			.value(value_w[i]),
			.age(age_w[i]),
			.next_value(next_w[i])
		);
	end

	// Sequence count saturates at the window; a result is due once it is full.
	always_comb begin
		seen_inc  = (samples.start_req ? (WW+1)'(0) : {1'b0, seen_q}) + (WW+1)'(1);
		seen_next = (seen_inc >= {1'b0, w_eff}) ? w_eff : seen_inc[WW-1:0];
		has_result = (seen_next == w_eff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= WINDOW_SIZE_RESET;
			seen_q        <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				window_size_q <= cfg_wdata;
			end
			if (accept) begin
				seen_q      <= seen_next;
				out_valid_q <= has_result;
			end else if (maxima.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// The new front of the queue is the maximum of the window.
	always_ff @(posedge clk) begin
		if (accept) begin
			out_max_q <= next_w[0];
		end
	end

	assign maxima.valid      = out_valid_q;
	assign maxima.window_max = out_max_q;

endmodule

>>> rtl/core/swm_checker.sv
// Port-level checks for the sliding window maximum block, bound to the top.
// Depends on swm_if and sliding_window_maximum.
module swm_checker (
	input logic       clk,
	input logic       arst_n,
	swm_in_if.sink    samples,
	swm_out_if.source maxima
);

	// A stalled result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		maxima.valid && !maxima.ready |=> maxima.valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its value.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		maxima.valid && !maxima.ready |=> $stable(maxima.window_max))
		else $error("result changed while stalled");

	// A result only follows an accepted sample or a result still waiting.
	a_out_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(maxima.valid) |-> $past(samples.valid && samples.ready))
		else $error("result without an accepted sample");

	// No sample is taken while the previous result has nowhere to go.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		maxima.valid && !maxima.ready |-> !samples.ready)
		else $error("sample taken while the result register is full");

endmodule

bind sliding_window_maximum swm_checker u_swm_checker (
	.clk(clk),
	.arst_n(arst_n),
	.samples(samples),
	.maxima(maxima)
);

>>> bench/tb.sv
// Self-checking testbench for sliding_window_maximum.
// It drives random and directed samples, predicts every window maximum and
// compares. Depends on swm_pkg, the swm_in_if/swm_out_if interfaces and the RTL.
module tb import swm_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_WINDOW  = 64;
	localparam int SAMPLE_BITS = 16;

	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

	// One item on the samples channel.
	typedef struct {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic                          start;
	} window_in_t;

	// Shapes of random sample runs. Rising runs empty the candidate queue,
	// falling runs fill it, narrow runs give many equal values.
	typedef enum int {FILL_FULL, FILL_NARROW, FILL_EXTREME, FILL_RISE, FILL_FALL} fill_mode_t;

	logic                        clk = 1'b0;
	logic                        arst_n;
	logic                        cfg_we;
	logic [WINDOW_SIZE_BITS-1:0] cfg_wdata;

	swm_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) samples_ch ();
	swm_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) maxima_ch ();

	sliding_window_maximum #(
		.MAX_WINDOW (MAX_WINDOW),
		.SAMPLE_BITS(SAMPLE_BITS)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.samples  (samples_ch),
		.maxima   (maxima_ch),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Items waiting to be sent, and window maxima waiting to be received.
	window_in_t                    pending[$];
	logic signed [SAMPLE_BITS-1:0] expected_max[$];

	// Idle rates in percent of cycles, changed between phases.
	int send_idle_pct;
	int recv_idle_pct;
	int errors;

	// Own copy of the block state: the monotonic candidate queue with the age
	// of each entry, the number of samples seen in this sequence, the register.
	logic signed [SAMPLE_BITS-1:0] cand_val[MAX_WINDOW];
	logic [WINDOW_SIZE_BITS-1:0]   cand_age[MAX_WINDOW];
	int                            cand_cnt;
	int                            seen_cnt;
	logic [WINDOW_SIZE_BITS-1:0]   window_reg;

	logic signed [SAMPLE_BITS-1:0] ramp_level;

	int phase_sizes[12] = '{1, 64, 0, 127, 2, 65, 5, 33, 3, 12, 0, 8};

	// Advances the candidate queue by one sample and queues the window maximum
	// when the sequence has seen a whole window.
	function automatic void advance_window(input logic signed [SAMPLE_BITS-1:0] s,
			input logic start);
		int w;
		int drop;
		w = window_reg;
		// A window of zero behaves as one, anything past the array as the full array.
		if (w < 1)
			w = 1;
		if (w > MAX_WINDOW)
			w = MAX_WINDOW;
		if (start) begin
			cand_cnt = 0;
			seen_cnt = 0;
		end
		// Ages stop at MAX_WINDOW; such an entry is outside any window anyway.
		for (int i = 0; i < cand_cnt; i++)
			if (cand_age[i] < MAX_WINDOW)
				cand_age[i]++;
		// The oldest entries sit at the front. After the window was lowered
		// several of them may leave at once.
		drop = 0;
		while (drop < cand_cnt && cand_age[drop] >= w)
			drop++;
		if (drop > 0) begin
			for (int i = drop; i < cand_cnt; i++) begin
				cand_val[i - drop] = cand_val[i];
				cand_age[i - drop] = cand_age[i];
			end
			cand_cnt -= drop;
		end
		// Strictly smaller entries can never be a maximum again; equal ones stay.
		while (cand_cnt > 0 && cand_val[cand_cnt - 1] < s)
			cand_cnt--;
		if (cand_cnt < MAX_WINDOW) begin
			cand_val[cand_cnt] = s;
			cand_age[cand_cnt] = '0;
			cand_cnt++;
		end
		seen_cnt++;
		if (seen_cnt > w)
			seen_cnt = w;
		if (seen_cnt == w)
			expected_max = {expected_max, cand_val[0]};
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(input fill_mode_t mode);
		logic signed [SAMPLE_BITS-1:0] v;
		case (mode)
			FILL_NARROW: begin
				v = SAMPLE_BITS'($urandom_range(6));
				v = v - SAMPLE_BITS'(3);
			end
			FILL_EXTREME: begin
				case ($urandom_range(3))
					0: v = SAMPLE_MIN;
					1: v = SAMPLE_MAX;
					2: v = '0;
					default: v = '1;
				endcase
			end
			FILL_RISE: begin
				ramp_level = ramp_level + SAMPLE_BITS'($urandom_range(1, 500));
				v = ramp_level;
			end
			FILL_FALL: begin
				ramp_level = ramp_level - SAMPLE_BITS'($urandom_range(0, 200));
				v = ramp_level;
			end
			default: v = SAMPLE_BITS'($urandom);
		endcase
		return v;
	endfunction

	task automatic add_item(input logic signed [SAMPLE_BITS-1:0] s, input logic start);
		window_in_t item;
		item.sample = s;
		item.start  = start;
		pending = {pending, item};
	endtask

	// Queues a stretch of random samples made of runs of one shape each.
	// New sequences are started only now and then, so that most windows fill.
	task automatic queue_burst(input int count, input logic first_start);
		fill_mode_t mode;
		int         run_left;
		run_left = 0;
		mode     = FILL_FULL;
		for (int n = 0; n < count; n++) begin
			if (run_left == 0) begin
				mode       = fill_mode_t'($urandom_range(4));
				ramp_level = SAMPLE_BITS'($urandom);
				// Long falling runs are what fills all MAX_WINDOW candidates.
				run_left   = (mode == FILL_FALL) ? $urandom_range(8, 90) : $urandom_range(1, 24);
			end
			add_item(pick_sample(mode), (n == 0) ? first_start : ($urandom_range(79) == 0));
			run_left--;
		end
	endtask

	// Waits until every queued item went in and every maximum came out, then
	// gives the block time to finish items that produce no result.
	task automatic settle();
		while (pending.size() != 0 || expected_max.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_window(input logic [WINDOW_SIZE_BITS-1:0] size);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= size;
		@(posedge clk);
		cfg_we     <= 1'b0;
		window_reg = size;
		@(negedge clk);
	endtask

	// Sender. An accepted item is fed to the predictor at the edge that takes
	// it. A waiting item is held until taken; gaps only fall between items.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			samples_ch.valid     <= 1'b0;
			samples_ch.sample    <= '0;
			samples_ch.start_req <= 1'b0;
		end else begin
			if (samples_ch.valid && samples_ch.ready) begin
				advance_window(samples_ch.sample, samples_ch.start_req);
				pending.delete(0);
			end
			if (samples_ch.valid && !samples_ch.ready) begin
				// Still waiting for the block to take the current item.
			end else if (pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				samples_ch.valid     <= 1'b1;
				samples_ch.sample    <= pending[0].sample;
				samples_ch.start_req <= pending[0].start;
			end else begin
				samples_ch.valid <= 1'b0;
			end
		end
	end

	// Receiver. Each maximum taken is checked against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			maxima_ch.ready <= 1'b0;
		end else begin
			if (maxima_ch.valid && maxima_ch.ready) begin
				if (expected_max.size() == 0) begin
					$display("%0t: window_max expected none, got %0d", $time,
						maxima_ch.window_max);
					errors++;
				end else if (maxima_ch.window_max !== expected_max[0]) begin
					$display("%0t: window_max expected %0d, got %0d", $time,
						expected_max[0], maxima_ch.window_max);
					errors++;
					expected_max.delete(0);
				end else begin
					expected_max.delete(0);
				end
			end
			maxima_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	initial begin
		// Every input is known from time zero, while reset is held low.
		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_wdata            = '0;
		samples_ch.valid     = 1'b0;
		samples_ch.sample    = '0;
		samples_ch.start_req = 1'b0;
		maxima_ch.ready      = 1'b0;
		errors               = 0;
		send_idle_pct        = 8;
		recv_idle_pct        = 63;
		window_reg           = WINDOW_SIZE_RESET;
		cand_cnt             = 0;
		seen_cnt             = 0;
		ramp_level           = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed items under the reset window of three. The first sequence
		// runs without a start request; later ones restart mid-stream. The
		// extremes set every sample bit both ways, and runs of equal values
		// check that ties stay in the queue.
		add_item(SAMPLE_MIN, 1'b0);
		add_item(SAMPLE_MAX, 1'b0);
		add_item(-16'sd1, 1'b0);
		add_item(16'sd0, 1'b0);
		add_item(16'sd0, 1'b0);
		add_item(16'sd0, 1'b0);
		add_item(16'sd100, 1'b1);
		add_item(16'sd100, 1'b0);
		add_item(16'sd100, 1'b0);
		add_item(-16'sd5, 1'b0);
		add_item(16'sh5555, 1'b0);
		add_item(16'shAAAA, 1'b0);
		add_item(SAMPLE_MIN, 1'b1);
		add_item(SAMPLE_MIN, 1'b0);
		add_item(SAMPLE_MIN, 1'b0);
		add_item(SAMPLE_MAX, 1'b0);
		add_item(16'sd7, 1'b1);
		add_item(16'sd9, 1'b1);
		settle();

		// Random phases, one window setting each. Going from 64 straight to 0
		// lowers the window mid-sequence by the most; 127 and 65 go past the
		// array and 0 stays below one. Each phase picks at random whether its first
		// burst continues the old sequence, so the new size can apply to a queue that is already full.
		phase_sizes[10] = $urandom_range(1, 127);
		for (int p = 0; p < 12; p++) begin
			if (p == 4) begin
				send_idle_pct = 63;
				recv_idle_pct = 8;
			end else if (p == 8) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			write_window(phase_sizes[p][WINDOW_SIZE_BITS-1:0]);
			queue_burst(32, $urandom_range(1));
			// No new items are queued here until every maximum has come out.
			settle();
			queue_burst(32, 1'b0);
			settle();
		end

		if (errors == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("tb: errors");
		$finish;
	end

endmodule
